>>> design/gba_pkg.sv
package gba_pkg;

  // Storage geometry.
  localparam int NUM_GROUPS  = 8;
  localparam int GROUP_BYTES = 1024;
  localparam int MEM_DEPTH   = NUM_GROUPS * GROUP_BYTES;
  localparam int MEM_AW      = $clog2(MEM_DEPTH);
  localparam int GRP_AW      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int BYTE_AW     = $clog2(GROUP_BYTES);
  localparam int SCAN_W      = $clog2(GROUP_BYTES + 1);

  // Field widths.
  localparam int MODE_W    = 3;
  localparam int GROUP_W   = 3;
  localparam int BIDX_W    = 10;
  localparam int DATA_W    = 8;
  localparam int CNT_W     = 17;
  localparam int GCNT_W    = 14;
  localparam int STATUS_W  = 2;
  localparam int NUMBER_W  = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 14;
  localparam int GIU_W     = 4;
  localparam int BPG_W     = 14;
  localparam int PROD_W    = GRP_AW + BPG_W;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  localparam logic [DATA_W-1:0] BYTE_FULL = 8'hFF;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_LOAD_BYTE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SET_GROUP = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SET_TOTAL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ_BYTE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ALLOCATE  = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_MISMATCH = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GROUPS_IN_USE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_GROUP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_NUMBER    = 2'd2;

  // Flat bitmap address of a byte within a group.
  function automatic logic [MEM_AW-1:0] mem_addr(input logic [GRP_AW-1:0] g,
                                                 input logic [BYTE_AW-1:0] b);
    int sum;
    sum = int'(g) * GROUP_BYTES + int'(b);
    return MEM_AW'(sum);
  endfunction

endpackage

>>> design/gba_ram.sv
module gba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> design/group_bitmap_allocator.sv
// First-fit unit allocator over per-group bitmaps held in one byte-wide RAM.
// After reset the block sweeps the bitmap RAM to zero, one byte per cycle;
// in_tready stays low meanwhile, while configuration writes are taken at any
// time. One request is handled at a time. Load, set-count and unknown modes
// go from acceptance straight to the done state; a byte read goes through
// the read state first. An allocation scans the bitmap of the chosen group
// through the single RAM port one byte per cycle until a byte has a free
// unit, then writes that bit back and forms the unit number; an allocation
// that finds no group with free units goes straight to the done state. A
// new request is taken while the previous result still waits in the output
// register.
module group_bitmap_allocator (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [gba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gba_pkg::CFG_W-1:0]         cfg_wdata,
  // Request channel.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: group[2:0], byte_index[12:3], byte_data[20:13], count_value[37:21], zero pad
  input  logic [gba_pkg::IN_DATA_W-1:0]     in_tdata,
  // tuser: mode[2:0]
  input  logic [gba_pkg::MODE_W-1:0]        in_tuser,
  // Result channel.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata: allocated_number[16:0], read_byte[24:17], total_free[41:25], zero pad
  output logic [gba_pkg::OUT_DATA_W-1:0]    out_tdata,
  // tuser: status[1:0]
  output logic [gba_pkg::STATUS_W-1:0]      out_tuser
);

  import gba_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_READ   = 7'b0000100,
    ST_SCAN   = 7'b0001000,
    ST_WRITE  = 7'b0010000,
    ST_NUMBER = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration.
  logic [GIU_W-1:0] groups_in_use_r;
  logic [BPG_W-1:0] bits_per_group_r;
  logic             base_number_r;

  // Counters.
  logic [GCNT_W-1:0] counts_r [NUM_GROUPS];
  logic [GCNT_W-1:0] counts_nxt [NUM_GROUPS];
  logic [CNT_W-1:0]  total_r, total_nxt;

  // Working registers.
  logic [MEM_AW-1:0]  clr_addr_r, clr_addr_nxt;
  logic [GRP_AW-1:0]  grp_r, grp_nxt;
  logic [SCAN_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic               data_vld_r, data_vld_nxt;
  logic [BYTE_AW-1:0] byte_idx_r, byte_idx_nxt;
  logic [DATA_W-1:0]  byte_val_r, byte_val_nxt;
  logic [2:0]         bit_r, bit_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;

  // Result waiting for the output register.
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [NUMBER_W-1:0] res_number_r, res_number_nxt;
  logic [DATA_W-1:0]   res_rbyte_r, res_rbyte_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [NUMBER_W-1:0] out_number_r, out_number_nxt;
  logic [DATA_W-1:0]   out_rbyte_r, out_rbyte_nxt;
  logic [CNT_W-1:0]    out_total_r, out_total_nxt;

  // RAM port.
  logic [MEM_AW-1:0] mem_addr_s;
  logic              mem_we;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] mem_rdata;

  // Request fields.
  logic [MODE_W-1:0]  req_mode;
  logic [GROUP_W-1:0] req_group;
  logic [BIDX_W-1:0]  req_bidx;
  logic [DATA_W-1:0]  req_data;
  logic [CNT_W-1:0]   req_count;
  logic               req_accept;
  logic               grp_ok;
  logic               addr_ok;

  // Group search and byte decode.
  logic              grp_any;
  logic [GRP_AW-1:0] grp_first;
  logic [2:0]        zero_bit;
  logic              byte_hit;
  logic              out_free;

  assign req_mode  = in_tuser;
  assign req_group = in_tdata[2:0];
  assign req_bidx  = in_tdata[12:3];
  assign req_data  = in_tdata[20:13];
  assign req_count = in_tdata[37:21];

  assign in_tready  = (state_r == ST_IDLE);
  assign req_accept = in_tvalid && in_tready;
  assign grp_ok     = int'(req_group) < NUM_GROUPS;
  assign addr_ok    = grp_ok && (int'(req_bidx) < GROUP_BYTES);
  assign out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {6'd0, out_total_r, out_rbyte_r, out_number_r};

  gba_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_DEPTH)
  ) u_bitmap (
    .clk   (clk),
    .addr  (mem_addr_s),
    .we    (mem_we),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // First group inside the searched range with a nonzero free count.
  always_comb begin
    grp_any   = 1'b0;
    grp_first = '0;
    for (int i = NUM_GROUPS - 1; i >= 0; i--) begin
      if ((i < int'(groups_in_use_r)) && (counts_r[i] != '0)) begin
        grp_any   = 1'b1;
        grp_first = GRP_AW'(i);
      end
    end
  end

  // Lowest clear bit of the byte coming out of the RAM.
  always_comb begin
    zero_bit = 3'd7;
    for (int i = 6; i >= 0; i--) begin
      if (!mem_rdata[i]) begin
        zero_bit = 3'(i);
      end
    end
  end

  assign byte_hit = data_vld_r && (mem_rdata != BYTE_FULL);

  always_comb begin
    state_nxt      = state_r;
    counts_nxt     = counts_r;
    total_nxt      = total_r;
    clr_addr_nxt   = clr_addr_r;
    grp_nxt        = grp_r;
    scan_idx_nxt   = scan_idx_r;
    data_vld_nxt   = 1'b0;
    byte_idx_nxt   = byte_idx_r;
    byte_val_nxt   = byte_val_r;
    bit_nxt        = bit_r;
    prod_nxt       = prod_r;
    res_status_nxt = res_status_r;
    res_number_nxt = res_number_r;
    res_rbyte_nxt  = res_rbyte_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_number_nxt = out_number_r;
    out_rbyte_nxt  = out_rbyte_r;
    out_total_nxt  = out_total_r;
    mem_addr_s     = mem_addr(GRP_AW'(req_group), BYTE_AW'(req_bidx));
    mem_we         = 1'b0;
    mem_wdata      = req_data;

    case (state_r)
      ST_CLEAR: begin
        mem_addr_s   = clr_addr_r;
        mem_we       = 1'b1;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == MEM_AW'(MEM_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_accept) begin
          res_status_nxt = STAT_OK;
          res_number_nxt = '0;
          res_rbyte_nxt  = '0;
          state_nxt      = ST_DONE;
          case (req_mode)
            MODE_LOAD_BYTE: begin
              mem_we = addr_ok;
            end
            MODE_SET_GROUP: begin
              if (grp_ok) begin
                counts_nxt[GRP_AW'(req_group)] = req_count[GCNT_W-1:0];
              end
            end
            MODE_SET_TOTAL: begin
              total_nxt = req_count;
            end
            MODE_READ_BYTE: begin
              if (addr_ok) begin
                state_nxt = ST_READ;
              end
            end
            MODE_ALLOCATE: begin
              if (grp_any) begin
                grp_nxt      = grp_first;
                scan_idx_nxt = '0;
                state_nxt    = ST_SCAN;
              end else begin
                res_status_nxt = STAT_FULL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        res_rbyte_nxt = mem_rdata;
        state_nxt     = ST_DONE;
      end
      ST_SCAN: begin
        // A read issued in one cycle is checked in the next one.
        mem_addr_s = mem_addr(grp_r, scan_idx_r[BYTE_AW-1:0]);
        if (byte_hit) begin
          byte_idx_nxt = BYTE_AW'(scan_idx_r - 1'b1);
          byte_val_nxt = mem_rdata;
          bit_nxt      = zero_bit;
          state_nxt    = ST_WRITE;
        end else if (int'(scan_idx_r) == GROUP_BYTES) begin
          if (data_vld_r) begin
            res_status_nxt = STAT_MISMATCH;
            state_nxt      = ST_DONE;
          end
        end else begin
          data_vld_nxt = 1'b1;
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      ST_WRITE: begin
        mem_addr_s        = mem_addr(grp_r, byte_idx_r);
        mem_we            = 1'b1;
        mem_wdata         = byte_val_r | (DATA_W'(1) << bit_r);
        counts_nxt[grp_r] = counts_r[grp_r] - 1'b1;
        if (total_r != '0) begin
          total_nxt = total_r - 1'b1;
        end
        prod_nxt  = PROD_W'(grp_r) * PROD_W'(bits_per_group_r);
        state_nxt = ST_NUMBER;
      end
      ST_NUMBER: begin
        res_number_nxt = NUMBER_W'(32'(prod_r) + 32'({byte_idx_r, 3'b000}) +
                                   32'(bit_r) + 32'(base_number_r));
        res_status_nxt = STAT_OK;
        state_nxt      = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_number_nxt = res_number_r;
          out_rbyte_nxt  = res_rbyte_r;
          out_total_nxt  = total_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_CLEAR;
      clr_addr_r       <= '0;
      data_vld_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      total_r          <= '0;
      groups_in_use_r  <= GIU_W'(8);
      bits_per_group_r <= BPG_W'(8192);
      base_number_r    <= 1'b1;
      for (int i = 0; i < NUM_GROUPS; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      data_vld_r  <= data_vld_nxt;
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
      counts_r    <= counts_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_GROUPS_IN_USE:  groups_in_use_r  <= cfg_wdata[GIU_W-1:0];
          CFG_BITS_PER_GROUP: bits_per_group_r <= cfg_wdata[BPG_W-1:0];
          CFG_BASE_NUMBER:    base_number_r    <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_r        <= grp_nxt;
    scan_idx_r   <= scan_idx_nxt;
    byte_idx_r   <= byte_idx_nxt;
    byte_val_r   <= byte_val_nxt;
    bit_r        <= bit_nxt;
    prod_r       <= prod_nxt;
    res_status_r <= res_status_nxt;
    res_number_r <= res_number_nxt;
    res_rbyte_r  <= res_rbyte_nxt;
    out_status_r <= out_status_nxt;
    out_number_r <= out_number_nxt;
    out_rbyte_r  <= out_rbyte_nxt;
    out_total_r  <= out_total_nxt;
  end

  // Only one request is in flight at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another one is in progress");

  // The allocation write-back sets exactly one bit that was clear.
  a_one_bit_set: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |-> (mem_we && $onehot(mem_wdata ^ byte_val_r)))
    else $error("allocation write-back does not set exactly one bit");

  // The bitmap is written only by the clearing sweep, a byte load or an allocation.
  a_ram_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((state_r == ST_CLEAR) || (state_r == ST_WRITE) ||
                (req_accept && (req_mode == MODE_LOAD_BYTE))))
    else $error("unexpected bitmap write");

  // A failed allocation never reports a unit number.
  a_fail_no_number: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != STAT_OK)) |-> (out_number_r == '0))
    else $error("failed allocation carries a unit number");

endmodule
